// File: hdl/rbfk_pkg.sv
package rbfk_pkg;

  // Default vector length
  localparam int FEATURES_DEFAULT = 16;

  // Field and register widths
  localparam int FEAT_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int DIST_W  = 40;
  localparam int SQ_W    = 32;
  localparam int KERN_W  = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] GAMMA_RESET = 16'd3277;
  localparam logic [CFG_W-1:0] COUNT_RESET = 16'd1;

  // Exponent arithmetic: log2(e) in Q1.30, 24 fraction bits of the exponent
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam int EXP_STEPS = 24;
  localparam int STEP_W    = 5;

  typedef logic [29:0] coef_tab_t [EXP_STEPS];

  // Build 2^-(2^-(k+1)) in Q0.30 by repeated integer square roots
  function automatic coef_tab_t build_coefs();
    coef_tab_t tab;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] rr;
    logic [63:0] b;
    c = 64'd1 << 29;
    for (int k = 0; k < EXP_STEPS; k++) begin
      v  = c << 30;
      rr = 64'd0;
      for (int i = 0; i < 32; i++) begin
        b = 64'd1 << (62 - 2 * i);
        if (v >= rr + b) begin
          v  = v - (rr + b);
          rr = (rr >> 1) + b;
        end else begin
          rr = rr >> 1;
        end
      end
      c = rr;
      tab[k] = c[29:0];
    end
    return tab;
  endfunction

  localparam coef_tab_t EXP_COEFS = build_coefs();

  // Controller to datapath
  typedef struct packed {
    logic take;      // input may be accepted this cycle
    logic square;    // form squared difference
    logic accum;     // add into the running distance
    logic scale;     // gamma times distance
    logic log_mul;   // convert to a base-2 exponent
    logic exp_step;  // one fraction bit of the power of two
    logic finish;    // final shift and saturation
    logic load_out;  // move the kernel value into the output register
  } rbfk_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sample_wrap;  // current element is the last of its sample
    logic exp_last;     // final fraction bit in progress
    logic out_free;     // output register can take a value
  } rbfk_status_t;

endpackage

// File: hdl/rbfk_ctrl.sv
module rbfk_ctrl
  import rbfk_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         op,
  input  rbfk_status_t status,
  output rbfk_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_LOG   = 3'd4;
  localparam logic [2:0] S_EXP   = 3'd5;
  localparam logic [2:0] S_SHIFT = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // Advance the sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid && op) state_next = S_SQ;
      S_SQ:    state_next = S_ACC;
      S_ACC:   state_next = status.sample_wrap ? S_SCALE : S_IDLE;
      S_SCALE: state_next = S_LOG;
      S_LOG:   state_next = S_EXP;
      S_EXP:   if (status.exp_last) state_next = S_SHIFT;
      S_SHIFT: state_next = S_OUT;
      S_OUT:   if (status.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Decode commands
  always_comb begin
    cmd          = '0;
    cmd.take     = (state == S_IDLE);
    cmd.square   = (state == S_SQ);
    cmd.accum    = (state == S_ACC);
    cmd.scale    = (state == S_SCALE);
    cmd.log_mul  = (state == S_LOG);
    cmd.exp_step = (state == S_EXP);
    cmd.finish   = (state == S_SHIFT);
    cmd.load_out = (state == S_OUT) && status.out_free;
  end

endmodule

// File: hdl/rbfk_datapath.sv
module rbfk_datapath
  import rbfk_pkg::*;
#(
  parameter int FEATURES = FEATURES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rbfk_cmd_t             cmd,
  output rbfk_status_t          status,
  input  logic                  in_valid,
  input  logic                  op,
  input  logic signed [FEAT_W-1:0] feature_value,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KERN_W-1:0]     kernel_value,
  output logic                  last
);

  localparam int POS_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FEATURES - 1);

  logic accept;

  logic [CFG_W-1:0] gamma_scale;
  logic [CFG_W-1:0] sample_count;

  logic [FEAT_W-1:0] ref_mem [FEATURES];
  logic [FEAT_W-1:0] ref_rd;
  logic [FEAT_W-1:0] sample_q;
  logic [POS_W-1:0]  ref_pos;
  logic [POS_W-1:0]  sample_pos;

  logic signed [FEAT_W:0] diff;
  logic [FEAT_W-1:0]      diff_abs;
  logic [SQ_W-1:0]        sq;
  logic [DIST_W:0]        sum_wide;
  logic [DIST_W-1:0]      dist_sum;

  logic [CFG_W-1:0] samples_done;
  logic [CFG_W-1:0] done_inc;
  logic             last_flag;

  logic [DIST_W+CFG_W-1:0] scaled;
  logic [DIST_W-1:0]       y;
  logic [59:0]             t_full;
  logic [5:0]              exp_int;
  logic [EXP_STEPS-1:0]    exp_frac;
  logic                    underflow;
  logic [STEP_W-1:0]       step;
  logic [30:0]             r;
  logic [60:0]             r_prod;
  logic [61:0]             r_round;
  logic [6:0]              sh;
  logic [63:0]             rnd;
  logic [63:0]             shifted;
  logic [KERN_W-1:0]       kern;

  assign accept = in_valid && cmd.take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_scale  <= GAMMA_RESET;
      sample_count <= COUNT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_GAMMA) gamma_scale <= cfg_data;
      if (cfg_index == CFG_COUNT) sample_count <= cfg_data;
    end
  end

  // Reference store: write on a reference transaction, read the sample slot
  always_ff @(posedge clk) begin
    if (accept && !op) ref_mem[ref_pos] <= feature_value;
    if (accept) begin
      ref_rd   <= ref_mem[sample_pos];
      sample_q <= feature_value;
    end
  end

  // Positions within the reference and sample vectors
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_pos    <= '0;
      sample_pos <= '0;
    end else begin
      if (accept && !op) ref_pos <= (ref_pos == POS_LAST) ? '0 : ref_pos + 1'b1;
      if (cmd.accum) sample_pos <= (sample_pos == POS_LAST) ? '0 : sample_pos + 1'b1;
    end
  end

  // Squared difference
  assign diff     = $signed({ref_rd[FEAT_W-1], ref_rd}) - $signed({sample_q[FEAT_W-1], sample_q});
  assign diff_abs = diff[FEAT_W] ? FEAT_W'(-diff) : diff[FEAT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.square) sq <= diff_abs * diff_abs;
  end

  // Saturating accumulation; clear once the kernel has taken the distance
  assign sum_wide = {1'b0, dist_sum} + (DIST_W + 1)'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_sum <= '0;
    end else if (cmd.accum) begin
      dist_sum <= sum_wide[DIST_W] ? '1 : sum_wide[DIST_W-1:0];
    end else if (cmd.scale) begin
      dist_sum <= '0;
    end
  end

  // Sample counter and last flag
  assign done_inc = samples_done + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_done <= '0;
      last_flag    <= 1'b0;
    end else if (cmd.accum && status.sample_wrap) begin
      last_flag    <= (done_inc == sample_count);
      samples_done <= (done_inc == sample_count) ? '0 : done_inc;
    end
  end

  // Gamma times distance, Q.24
  assign scaled = gamma_scale * dist_sum;

  always_ff @(posedge clk) begin
    if (cmd.scale) y <= scaled[DIST_W+CFG_W-1:CFG_W];
  end

  // Base-2 exponent: integer part and fraction bits
  assign t_full = y[28:0] * LOG2E_Q30;

  always_ff @(posedge clk) begin
    if (cmd.log_mul) begin
      underflow <= |y[DIST_W-1:29];
      exp_int   <= t_full[59:54];
      exp_frac  <= t_full[53:30];
    end else if (cmd.exp_step) begin
      exp_frac  <= {exp_frac[EXP_STEPS-2:0], 1'b0};
    end
  end

  // Power of two of the fraction, one bit a cycle through a shared multiplier
  assign r_prod  = r * EXP_COEFS[step];
  assign r_round = {1'b0, r_prod} + (62'd1 << 29);

  always_ff @(posedge clk) begin
    if (cmd.log_mul) begin
      r    <= 31'd1 << 30;
      step <= '0;
    end else if (cmd.exp_step) begin
      if (exp_frac[EXP_STEPS-1]) r <= r_round[60:30];
      step <= step + 1'b1;
    end
  end

  // Shift by the integer part with round half up, then saturate; zero on underflow
  assign sh      = 7'd14 + 7'(exp_int);
  assign rnd     = 64'(r) + (64'd1 << (sh - 7'd1));
  assign shifted = rnd >> sh;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (underflow) begin
        kern <= '0;
      end else if (|shifted[63:KERN_W]) begin
        kern <= '1;
      end else begin
        kern <= shifted[KERN_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      kernel_value <= kern;
      last         <= last_flag;
    end
  end

  // Status back to the controller
  always_comb begin
    status             = '0;
    status.sample_wrap = (sample_pos == POS_LAST);
    status.exp_last    = (step == STEP_W'(EXP_STEPS - 1));
    status.out_free    = !out_valid || !out_stall;
  end

endmodule

// File: hdl/rbf_kernel_row.sv
// Channel   Handshake             Payload
// input     in_valid / in_stall   op, feature_value
// output    out_valid / out_stall kernel_value, last
// config    cfg_write             cfg_index, cfg_data
//
// A reference element is taken in the idle state, which it does not leave; a
// sample element passes through the square and accumulate states. The last
// element of a sample then goes through scale, log, 24 exponent steps of the
// shared fraction multiplier, shift, and output, which waits on out_free.
// Reset is synchronous and clears positions, distance, counter and out_valid.
// in_stall is high while a transaction is in progress; a result waits in the
// output register while the next transactions are taken.
module rbf_kernel_row
  import rbfk_pkg::*;
#(
  parameter int FEATURES = FEATURES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     op,
  input  logic signed [FEAT_W-1:0] feature_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [KERN_W-1:0]        kernel_value,
  output logic                     last,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  rbfk_cmd_t    cmd;
  rbfk_status_t status;

  // Hold off input while a transaction is being worked
  assign in_stall = !cmd.take;

  rbfk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .status   (status),
    .cmd      (cmd)
  );

  rbfk_datapath #(
    .FEATURES (FEATURES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_valid      (in_valid),
    .op            (op),
    .feature_value (feature_value),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kernel_value  (kernel_value),
    .last          (last)
  );

endmodule
